// ===== src/mmc_pkg.sv =====
`timescale 1ns / 1ps

package mmc_pkg;

  // Three magnetometer axes, handled in the order X, Y, Z.
  localparam int AXES = 3;

  // Soft-iron scale words are always 16 bits wide and saturate at the top code.
  localparam int SCALE_BITS = 16;
  localparam logic [SCALE_BITS-1:0] SCALE_MAX = '1;

  // Entries in the snapshot queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Sequencer states of the back part.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_t;

endpackage

// ===== src/mmc_if.sv =====
`timescale 1ns / 1ps

// One beat carries one three-axis sample and the end-of-run mark.
interface mmc_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mag_x;
  logic signed [SAMPLE_BITS-1:0] mag_y;
  logic signed [SAMPLE_BITS-1:0] mag_z;
  logic                          final_sample;

  modport source (output valid, mag_x, mag_y, mag_z, final_sample, input ready);
  modport sink   (input valid, mag_x, mag_y, mag_z, final_sample, output ready);
endinterface

// One beat carries the calibration result of one run.
interface mmc_result_if
  import mmc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] offset_x;
  logic signed [SAMPLE_BITS-1:0] offset_y;
  logic signed [SAMPLE_BITS-1:0] offset_z;
  logic        [SCALE_BITS-1:0]  scale_x;
  logic        [SCALE_BITS-1:0]  scale_y;
  logic        [SCALE_BITS-1:0]  scale_z;
  logic                          flat_axis;

  modport source (output valid, offset_x, offset_y, offset_z, scale_x, scale_y, scale_z,
                  flat_axis, input ready);
  modport sink   (input valid, offset_x, offset_y, offset_z, scale_x, scale_y, scale_z,
                  flat_axis, output ready);
endinterface

// ===== src/mag_min_max_calibration_top.sv =====
// Throughput: one sample beat per cycle; the front never stalls while a queue slot is free.
// A final sample's result beat waits for the bit-serial divider, which runs once for each
// axis with a nonzero range.
// Two finished runs can wait in the snapshot queue while the divider works.
// Reset (rst, synchronous, active high) empties the queue, drops the result beat and
// returns every running extreme to its start value; no clearing pass is needed.
`timescale 1ns / 1ps

// The front folds each accepted sample into per-axis running minimum and maximum
// registers in the same cycle. When a beat carries the end-of-run mark, the front
// pushes the folded extremes into a small snapshot queue and restarts the extremes.
//
// The back pops one snapshot at a time. It first forms the per-axis ranges and the
// floored midpoints (the hard-iron offsets), then the sum of the three ranges. For
// each axis it divides the sum, shifted up by the fraction width, by three times the
// axis range, one quotient bit per cycle. A zero range skips the division and gives
// the saturated scale directly; a quotient that does not fit in 16 bits saturates as
// well. Either case raises the flat-axis flag. The finished result sits in an output
// register, so the sink can leave a result waiting while the back works on the next one.
module mag_min_max_calibration_top
  import mmc_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  mmc_sample_if.sink   samples,
  mmc_result_if.source results
);

  localparam int SNAP_BITS = 6 * SAMPLE_BITS;

  logic                 push_valid;
  logic                 push_ready;
  logic [SNAP_BITS-1:0] push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [SNAP_BITS-1:0] pop_data;

  mmc_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mmc_queue #(
    .WIDTH (SNAP_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mmc_back #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .results   (results)
  );

endmodule

// ===== src/mmc_front.sv =====
`timescale 1ns / 1ps

module mmc_front
  import mmc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  mmc_sample_if.sink                 samples,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [6*SAMPLE_BITS-1:0]   push_data
);

  localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] NEG_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] low   [AXES];
  logic signed [SAMPLE_BITS-1:0] high  [AXES];
  logic signed [SAMPLE_BITS-1:0] smp   [AXES];
  logic signed [SAMPLE_BITS-1:0] low_f [AXES];
  logic signed [SAMPLE_BITS-1:0] high_f[AXES];
  logic                          accept;

  // A final sample needs a free queue slot, so the queue sets ready for all beats.
  assign samples.ready = push_ready;
  assign accept        = samples.valid && push_ready;
  assign push_valid    = samples.valid && samples.final_sample;

  assign smp[0] = samples.mag_x;
  assign smp[1] = samples.mag_y;
  assign smp[2] = samples.mag_z;

  always_comb begin
    push_data = '0;
    for (int a = 0; a < AXES; a++) begin
      low_f[a]  = (smp[a] < low[a])  ? smp[a] : low[a];
      high_f[a] = (smp[a] > high[a]) ? smp[a] : high[a];
      push_data[2*a*SAMPLE_BITS     +: SAMPLE_BITS] = low_f[a];
      push_data[(2*a+1)*SAMPLE_BITS +: SAMPLE_BITS] = high_f[a];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (rst || (accept && samples.final_sample)) begin
        low[a]  <= POS_MAX;
        high[a] <= NEG_MAX;
      end else if (accept) begin
        low[a]  <= low_f[a];
        high[a] <= high_f[a];
      end
    end
  end

endmodule

// ===== src/mmc_queue.sv =====
`timescale 1ns / 1ps

module mmc_queue
  import mmc_pkg::*;
#(
  parameter int WIDTH = 96
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mmc_back.sv =====
`timescale 1ns / 1ps

module mmc_back
  import mmc_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  logic [6*SAMPLE_BITS-1:0] pop_data,
  mmc_result_if.source             results
);

  localparam int SB = SAMPLE_BITS;
  localparam int RW = SB + 2;                // range sum and divisor width
  localparam int DW = RW + SCALE_FRAC_BITS;  // dividend and quotient width
  localparam int CW = $clog2(DW + 1);

  back_state_t       state;
  logic [1:0]        axis;
  logic [SB-1:0]     rng [AXES];
  logic [SB-1:0]     ofs [AXES];
  logic [SCALE_BITS-1:0] scl [AXES];
  logic              flag;
  logic [RW-1:0]     sum;
  logic [RW-1:0]     rem;
  logic [RW-1:0]     dsr;
  logic [DW-1:0]     dvd;
  logic [CW-1:0]     cnt;

  logic              res_valid;
  logic [SB-1:0]     res_ofs [AXES];
  logic [SCALE_BITS-1:0] res_scl [AXES];
  logic              res_flag;

  logic [RW:0]       trial;
  logic              ge;
  logic [RW-1:0]     rem_next;
  logic [DW-1:0]     dvd_next;
  logic [SB:0]       diff [AXES];
  logic [SB:0]       twice [AXES];
  logic              last_axis;

  assign pop_ready = (state == ST_IDLE);
  assign last_axis = (axis == 2'(AXES - 1));

  // Unpack the snapshot: range and twice the midpoint, both in SB+1 bits.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      diff[a]  = {pop_data[(2*a+2)*SB-1], pop_data[(2*a+1)*SB +: SB]}
               - {pop_data[(2*a+1)*SB-1], pop_data[2*a*SB +: SB]};
      twice[a] = {pop_data[(2*a+2)*SB-1], pop_data[(2*a+1)*SB +: SB]}
               + {pop_data[(2*a+1)*SB-1], pop_data[2*a*SB +: SB]};
    end
  end

  // One restoring division step.
  always_comb begin
    trial    = {rem, dvd[DW-1]};
    ge       = (trial >= {1'b0, dsr});
    rem_next = ge ? RW'(trial - {1'b0, dsr}) : RW'(trial);
    dvd_next = {dvd[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            for (int a = 0; a < AXES; a++) begin
              rng[a] <= diff[a][SB-1:0];
              ofs[a] <= twice[a][SB:1];
            end
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum   <= RW'(rng[0]) + RW'(rng[1]) + RW'(rng[2]);
          axis  <= '0;
          flag  <= 1'b0;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (rng[axis] == '0) begin
            scl[axis] <= SCALE_MAX;
            flag      <= 1'b1;
            axis      <= axis + 1'b1;
            state     <= last_axis ? ST_OUT : ST_LOAD;
          end else begin
            dsr   <= {1'b0, rng[axis], 1'b0} + RW'(rng[axis]);
            dvd   <= {sum, {SCALE_FRAC_BITS{1'b0}}};
            rem   <= '0;
            cnt   <= CW'(DW);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          dvd <= dvd_next;
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            if (dvd_next[DW-1:SCALE_BITS] != '0) begin
              scl[axis] <= SCALE_MAX;
              flag      <= 1'b1;
            end else begin
              scl[axis] <= dvd_next[SCALE_BITS-1:0];
            end
            axis  <= axis + 1'b1;
            state <= last_axis ? ST_OUT : ST_LOAD;
          end
        end
        ST_OUT: begin
          if (!res_valid || results.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: holds a result until the sink takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_OUT && (!res_valid || results.ready)) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!res_valid || results.ready)) begin
      for (int a = 0; a < AXES; a++) begin
        res_ofs[a] <= ofs[a];
        res_scl[a] <= scl[a];
      end
      res_flag <= flag;
    end
  end

  assign results.valid     = res_valid;
  assign results.offset_x  = res_ofs[0];
  assign results.offset_y  = res_ofs[1];
  assign results.offset_z  = res_ofs[2];
  assign results.scale_x   = res_scl[0];
  assign results.scale_y   = res_scl[1];
  assign results.scale_z   = res_scl[2];
  assign results.flat_axis = res_flag;

endmodule
